@@ hw/rtl/rnf_pkg.sv @@
// Shared types and constants for the RTP NAL fragmenter.
// No dependencies; imported by the front, queue, back and top modules.
`timescale 1ns / 1ps

package rnf_pkg;

  // RTP header fixed fields
  localparam logic [7:0]  RTP_VERSION   = 8'h80;
  localparam logic [7:0]  RTP_PTYPE     = 8'h60;
  localparam logic [31:0] RTP_SSRC      = 32'hDEADBEEF;

  // FU header construction
  localparam logic [7:0]  FUA_IND_MASK  = 8'hE0;
  localparam logic [7:0]  FUA_TYPE      = 8'd28;
  localparam logic [7:0]  FU265_MASK    = 8'h81;
  localparam logic [7:0]  FU265_TYPE    = 8'd98;   // type 49 shifted into bits 6:1
  localparam logic [7:0]  FU265_LAYER   = 8'h01;
  localparam logic [7:0]  FU_START      = 8'h80;
  localparam logic [7:0]  FU_END        = 8'h40;

  localparam logic [4:0]  AVC_NON_IDR   = 5'd1;
  localparam logic [4:0]  AVC_IDR       = 5'd5;
  localparam logic [5:0]  HEVC_TRAIL    = 6'd1;
  localparam logic [5:0]  HEVC_IDR      = 6'd19;

  // Unit framing
  localparam logic [23:0] PREFIX_LEN    = 24'd4;
  localparam logic [23:0] MIN_LEN       = 24'd5;

  // MTU handling
  localparam logic [11:0] MTU_FLOOR     = 12'd16;
  localparam logic [11:0] MTU_LIMIT     = 12'd4093;
  localparam logic [11:0] MTU_RESET     = 12'd1400;

  // One request from the front to the back: a data byte plus what precedes it.
  typedef struct packed {
    logic [7:0]  data;
    logic        data_last;   // data byte ends its packet
    logic        unsup;       // oversize unit of unhandled type
    logic        hdr;         // RTP header goes ahead of the data byte
    logic        fu;          // FU bytes follow the header
    logic        h265;        // FU uses the two-byte H.265 payload header
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [15:0] seq;
  } rnf_req_t;

endpackage

@@ hw/rtl/rnf_front.sv @@
// Front end: tracks position in each NAL unit, picks single or FU mode and
// turns every accepted byte into at most one request. Depends on rnf_pkg.
`timescale 1ns / 1ps

module rnf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic [23:0]     unit_length_i,
  input  logic [11:0]     mtu_i,
  output logic            req_valid_o,
  output rnf_pkg::rnf_req_t req_o
);
  import rnf_pkg::*;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_FUA    = 2'd1;
  localparam logic [1:0] MODE_FU265  = 2'd2;
  localparam logic [1:0] MODE_UNSUP  = 2'd3;

  logic [23:0] pos_q, pos_d;
  logic [23:0] len_q, len_d;
  logic [15:0] seq_q, seq_d;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  fuind_q, fuind_d;
  logic [5:0]  utype_q, utype_d;
  logic [11:0] chunk_q, chunk_d;

  logic [11:0] eff_mtu;
  logic [24:0] pos_inc;
  logic        end_byte;
  logic [23:0] size_hdr;
  logic [23:0] size_frag;
  logic [23:0] first_pay;
  logic [11:0] chunk_new;
  logic [4:0]  avc;
  logic [5:0]  hevc;
  logic        req_valid;
  rnf_req_t    req;

  always_comb begin
    if (mtu_i < MTU_FLOOR) begin
      eff_mtu = MTU_FLOOR;
    end else if (mtu_i > MTU_LIMIT) begin
      eff_mtu = MTU_LIMIT;
    end else begin
      eff_mtu = mtu_i;
    end
  end

  always_comb begin
    len_d = len_q;
    if (pos_q == '0) begin
      len_d = (unit_length_i < MIN_LEN) ? MIN_LEN : unit_length_i;
    end
    pos_inc   = {1'b0, pos_q} + 25'd1;
    end_byte  = (pos_inc == {1'b0, len_d});
    pos_d     = (pos_inc >= {1'b0, len_d}) ? '0 : pos_inc[23:0];
    size_hdr  = len_d - PREFIX_LEN;
    size_frag = len_d - pos_q;
    first_pay = (mode_q == MODE_FUA) ? PREFIX_LEN + 24'd1 : PREFIX_LEN + 24'd2;
    avc       = data_byte_i[4:0];
    hevc      = data_byte_i[6:1];

    mode_d    = mode_q;
    fuind_d   = fuind_q;
    utype_d   = utype_q;
    chunk_d   = chunk_q;
    chunk_new = chunk_q;

    req_valid     = 1'b0;
    req.data      = data_byte_i;
    req.data_last = end_byte;
    req.unsup     = 1'b0;
    req.hdr       = 1'b0;
    req.fu        = 1'b0;
    req.h265      = (mode_q == MODE_FU265);
    req.fu_ind    = fuind_q;
    req.fu_hdr    = {2'b00, utype_q};
    req.seq       = seq_q;

    if (pos_q == PREFIX_LEN) begin
      // NAL header byte: decide how the whole unit goes out
      chunk_d = '0;
      if (size_hdr <= {12'd0, eff_mtu}) begin
        mode_d = MODE_SINGLE;
      end else if (avc == AVC_NON_IDR || avc == AVC_IDR) begin
        mode_d  = MODE_FUA;
        fuind_d = (data_byte_i & FUA_IND_MASK) | FUA_TYPE;
        utype_d = {1'b0, avc};
      end else if (hevc == HEVC_TRAIL || hevc == HEVC_IDR) begin
        mode_d  = MODE_FU265;
        fuind_d = (data_byte_i & FU265_MASK) | FU265_TYPE;
        utype_d = hevc;
      end else begin
        mode_d = MODE_UNSUP;
      end
      if (mode_d == MODE_SINGLE || mode_d == MODE_UNSUP) begin
        req_valid = 1'b1;
        req.hdr   = 1'b1;
        req.unsup = (mode_d == MODE_UNSUP);
      end
    end else if (pos_q > PREFIX_LEN) begin
      if (mode_q == MODE_SINGLE || mode_q == MODE_UNSUP) begin
        req_valid = 1'b1;
        req.unsup = (mode_q == MODE_UNSUP);
      end else if (!(mode_q == MODE_FU265 && pos_q == PREFIX_LEN + 24'd1)) begin
        req_valid = 1'b1;
        if (chunk_q == '0) begin
          // fragment start
          req.hdr    = 1'b1;
          req.fu     = 1'b1;
          req.fu_hdr = {2'b00, utype_q}
                     | ((pos_q == first_pay) ? FU_START : 8'h00)
                     | ((size_frag <= {12'd0, eff_mtu}) ? FU_END : 8'h00);
          chunk_new  = (size_frag > {12'd0, eff_mtu}) ? eff_mtu : size_frag[11:0];
        end
        chunk_d       = chunk_new - 12'd1;
        req.data_last = (chunk_d == '0);
      end
    end

    seq_d = (req_valid && req.hdr) ? seq_q + 16'd1 : seq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      seq_q   <= '0;
      mode_q  <= MODE_SINGLE;
      fuind_q <= '0;
      utype_q <= '0;
      chunk_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      seq_q   <= seq_d;
      mode_q  <= mode_d;
      fuind_q <= fuind_d;
      utype_q <= utype_d;
      chunk_q <= chunk_d;
    end
  end

  assign req_valid_o = req_valid;
  assign req_o       = req;

endmodule

@@ hw/rtl/rnf_queue.sv @@
// Short request queue between front and back ends.
// Depends on rnf_pkg for the request type.
`timescale 1ns / 1ps

module rnf_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  rnf_pkg::rnf_req_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              valid_o,
  output rnf_pkg::rnf_req_t rd_data_o
);
  import rnf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rnf_req_t        mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/rnf_back.sv @@
// Back end: expands each request into RTP header and FU bytes where flagged, then the data
// byte, one byte per cycle into an output register while it is empty or popped. Depends on rnf_pkg.
`timescale 1ns / 1ps

module rnf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  rnf_pkg::rnf_req_t req_i,
  output logic              req_done_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        out_byte_o,
  output logic              packet_first_o,
  output logic              packet_last_o,
  output logic              run_last_o,
  output logic              oversize_unsupported_o
);
  import rnf_pkg::*;

  // byte slots within one request
  localparam logic [3:0] SLOT_HDR_LAST = 4'd11;
  localparam logic [3:0] SLOT_FU_IND   = 4'd12;
  localparam logic [3:0] SLOT_FU_LAYER = 4'd13;
  localparam logic [3:0] SLOT_FU_HDR   = 4'd14;
  localparam logic [3:0] SLOT_DATA     = 4'd15;

  logic       busy_q, busy_d;
  logic [3:0] slot_q, slot_d;
  logic [3:0] slot;
  logic       step;

  logic       ov_q;
  logic [7:0] ob_q;
  logic       of_q, ol_q, orl_q, ou_q;
  logic [7:0] nb;

  assign step = req_valid_i && (!ov_q || pop_i);
  assign slot = busy_q ? slot_q : (req_i.hdr ? 4'd0 : SLOT_DATA);

  always_comb begin
    case (slot)
      4'd0:          nb = RTP_VERSION;
      4'd1:          nb = RTP_PTYPE;
      4'd2:          nb = req_i.seq[15:8];
      4'd3:          nb = req_i.seq[7:0];
      4'd8:          nb = RTP_SSRC[31:24];
      4'd9:          nb = RTP_SSRC[23:16];
      4'd10:         nb = RTP_SSRC[15:8];
      SLOT_HDR_LAST: nb = RTP_SSRC[7:0];
      SLOT_FU_IND:   nb = req_i.fu_ind;
      SLOT_FU_LAYER: nb = FU265_LAYER;
      SLOT_FU_HDR:   nb = req_i.fu_hdr;
      SLOT_DATA:     nb = req_i.data;
      default:       nb = 8'h00;   // timestamp
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (step) begin
      busy_d = (slot != SLOT_DATA);
      if (slot == SLOT_HDR_LAST) begin
        slot_d = req_i.fu ? SLOT_FU_IND : SLOT_DATA;
      end else if (slot == SLOT_FU_IND) begin
        slot_d = req_i.h265 ? SLOT_FU_LAYER : SLOT_FU_HDR;
      end else begin
        slot_d = slot + 4'd1;
      end
    end
  end

  assign req_done_o = step && (slot == SLOT_DATA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
      if (step) begin
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ob_q  <= nb;
      of_q  <= (slot == 4'd0);
      ol_q  <= (slot == SLOT_DATA) && req_i.data_last;
      orl_q <= (slot == SLOT_DATA);
      ou_q  <= req_i.unsup;
    end
  end

  assign empty_o                = !ov_q;
  assign out_byte_o             = ob_q;
  assign packet_first_o         = of_q;
  assign packet_last_o          = ol_q;
  assign run_last_o             = orl_q;
  assign oversize_unsupported_o = ou_q;

endmodule

@@ hw/rtl/rtp_nal_fragmenter.sv @@
// RTP packetizer for H.264/H.265 NAL unit byte streams, FU fragmentation.
// Each request is written into the request queue; the back end registers output bytes.
// Throughput: input takes one byte per cycle while the request queue has room; the back
// end emits one byte per cycle while its output register is empty or popped; a start
// of packet adds the RTP header (and FU bytes), so input stalls once the queue fills.
// Reset: all control state clears; mtu_q returns to 1400.
`timescale 1ns / 1ps

module rtp_nal_fragmenter #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic [23:0] unit_length_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        packet_first_o,
  output logic        packet_last_o,
  output logic        run_last_o,
  output logic        oversize_unsupported_o,
  input  logic        mtu_we_i,
  input  logic [11:0] mtu_wdata_i
);
  import rnf_pkg::*;

  logic [11:0] mtu_q;
  logic        accept;
  logic        req_valid;
  rnf_req_t    req;
  logic        q_full;
  logic        head_valid;
  rnf_req_t    head;
  logic        head_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= MTU_RESET;
    end else if (mtu_we_i) begin
      mtu_q <= mtu_wdata_i;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  rnf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .unit_length_i (unit_length_i),
    .mtu_i         (mtu_q),
    .req_valid_o   (req_valid),
    .req_o         (req)
  );

  rnf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept && req_valid),
    .wr_data_i (req),
    .full_o    (q_full),
    .rd_i      (head_done),
    .valid_o   (head_valid),
    .rd_data_o (head)
  );

  rnf_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .req_valid_i            (head_valid),
    .req_i                  (head),
    .req_done_o             (head_done),
    .empty_o                (empty),
    .pop_i                  (pop),
    .out_byte_o             (out_byte_o),
    .packet_first_o         (packet_first_o),
    .packet_last_o          (packet_last_o),
    .run_last_o             (run_last_o),
    .oversize_unsupported_o (oversize_unsupported_o)
  );

endmodule

@@ dv/rtp_nal_fragmenter_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rtp_nal_fragmenter: NAL unit bytes in, RTP packet bytes out.
// Depends on rnf_pkg and the fragmenter RTL; a built-in packetizer predicts every output byte.

module rtp_nal_fragmenter_tb;
  import rnf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_BYTES  = 40;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_BYTES   = 8;

  typedef enum logic [1:0] {UM_SINGLE, UM_FUA, UM_FU265, UM_UNSUP} unit_mode_e;

  typedef struct packed {
    logic [7:0]  data;
    logic [23:0] len;
  } nal_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       run_last;
    logic       unsup;
  } rtp_byte_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        push       = 1'b0;
  logic        full;
  logic [7:0]  nal_byte   = 8'h00;
  logic [23:0] nal_len_in = 24'h0;
  logic        empty;
  logic        pop        = 1'b0;
  logic [7:0]  out_byte;
  logic        out_first;
  logic        out_last;
  logic        out_run_last;
  logic        out_unsup;
  logic        mtu_we     = 1'b0;
  logic [11:0] mtu_wdata  = 12'h0;

  // packetizer model state
  logic [11:0]  mtu_setting = MTU_RESET;
  int unsigned  nal_pos     = 0;
  int unsigned  nal_len     = 0;
  logic [15:0]  rtp_seq     = 16'h0;
  unit_mode_e   cur_mode    = UM_SINGLE;
  logic [7:0]   fu_ind_byte = 8'h0;
  logic [5:0]   fu_type     = 6'h0;
  int unsigned  frag_left   = 0;

  nal_byte_t nal_bytes_pending[$];
  nal_byte_t parked_bytes[$];
  rtp_byte_t rtp_bytes_exp[$];

  logic        nal_taken        = 1'b0;
  int unsigned src_wait         = 0;
  int unsigned sink_wait        = 0;
  int unsigned sink_hold_cycles = 0;
  bit          src_idle_on      = 1'b1;
  bit          sink_idle_on     = 1'b1;

  int unsigned cycle_count       = 0;
  int unsigned bytes_queued      = 0;
  int unsigned bytes_taken       = 0;
  int unsigned rtp_bytes_checked = 0;
  int unsigned packets_seen      = 0;
  int unsigned mtu_writes        = 0;
  int unsigned mismatches        = 0;

  rtp_nal_fragmenter i_dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .push                   (push),
    .full                   (full),
    .data_byte_i            (nal_byte),
    .unit_length_i          (nal_len_in),
    .empty                  (empty),
    .pop                    (pop),
    .out_byte_o             (out_byte),
    .packet_first_o         (out_first),
    .packet_last_o          (out_last),
    .run_last_o             (out_run_last),
    .oversize_unsupported_o (out_unsup),
    .mtu_we_i               (mtu_we),
    .mtu_wdata_i            (mtu_wdata)
  );

  always #10 clk = ~clk;

  function automatic int unsigned mtu_eff();
    if (mtu_setting < MTU_FLOOR) return MTU_FLOOR;
    if (mtu_setting > MTU_LIMIT) return MTU_LIMIT;
    return mtu_setting;
  endfunction

  function automatic void push_rtp_byte(input logic [7:0] b, input logic first,
                                        input logic last, input logic unsup);
    rtp_byte_t rb;
    rb.data     = b;
    rb.first    = first;
    rb.last     = last;
    rb.run_last = 1'b0;
    rb.unsup    = unsup;
    rtp_bytes_exp.push_back(rb);
  endfunction

  function automatic void push_rtp_header(input logic unsup);
    push_rtp_byte(RTP_VERSION, 1'b1, 1'b0, unsup);
    push_rtp_byte(RTP_PTYPE, 1'b0, 1'b0, unsup);
    push_rtp_byte(rtp_seq[15:8], 1'b0, 1'b0, unsup);
    push_rtp_byte(rtp_seq[7:0], 1'b0, 1'b0, unsup);
    repeat (4) push_rtp_byte(8'h00, 1'b0, 1'b0, unsup);
    push_rtp_byte(RTP_SSRC[31:24], 1'b0, 1'b0, unsup);
    push_rtp_byte(RTP_SSRC[23:16], 1'b0, 1'b0, unsup);
    push_rtp_byte(RTP_SSRC[15:8], 1'b0, 1'b0, unsup);
    push_rtp_byte(RTP_SSRC[7:0], 1'b0, 1'b0, unsup);
    rtp_seq = rtp_seq + 16'd1;
  endfunction

  // Expected RTP bytes caused by one accepted NAL byte.
  function automatic void packetize_nal_byte(input logic [7:0] b, input logic [23:0] len);
    int unsigned pos;
    int unsigned size;
    int unsigned m;
    int unsigned first_pay;
    int unsigned n0;
    logic [7:0]  fu_hdr;
    rtp_byte_t   tail;
    n0 = rtp_bytes_exp.size();
    if (nal_pos == 0) nal_len = (len < MIN_LEN) ? MIN_LEN : len;
    pos = nal_pos;
    m = mtu_eff();
    if (pos == PREFIX_LEN) begin
      size = nal_len - PREFIX_LEN;
      frag_left = 0;
      if (size <= m) begin
        cur_mode = UM_SINGLE;
      end else if (b[4:0] == AVC_NON_IDR || b[4:0] == AVC_IDR) begin
        cur_mode = UM_FUA;
        fu_ind_byte = (b & FUA_IND_MASK) | FUA_TYPE;
        fu_type = {1'b0, b[4:0]};
      end else if (b[6:1] == HEVC_TRAIL || b[6:1] == HEVC_IDR) begin
        cur_mode = UM_FU265;
        fu_ind_byte = (b & FU265_MASK) | FU265_TYPE;
        fu_type = b[6:1];
      end else begin
        cur_mode = UM_UNSUP;
      end
      if (cur_mode == UM_SINGLE || cur_mode == UM_UNSUP) begin
        push_rtp_header(cur_mode == UM_UNSUP);
        push_rtp_byte(b, 1'b0, pos + 1 == nal_len, cur_mode == UM_UNSUP);
      end
    end else if (pos > PREFIX_LEN) begin
      if (cur_mode == UM_SINGLE || cur_mode == UM_UNSUP) begin
        push_rtp_byte(b, 1'b0, pos + 1 == nal_len, cur_mode == UM_UNSUP);
      end else if (!(cur_mode == UM_FU265 && pos == PREFIX_LEN + 1)) begin
        // every byte but the second H.265 header byte, which is consumed silently
        first_pay = (cur_mode == UM_FUA) ? PREFIX_LEN + 1 : PREFIX_LEN + 2;
        if (frag_left == 0) begin
          size = nal_len - pos;
          fu_hdr = {2'b00, fu_type};
          if (pos == first_pay) fu_hdr |= FU_START;
          if (size <= m) fu_hdr |= FU_END;
          push_rtp_header(1'b0);
          push_rtp_byte(fu_ind_byte, 1'b0, 1'b0, 1'b0);
          if (cur_mode == UM_FU265) push_rtp_byte(FU265_LAYER, 1'b0, 1'b0, 1'b0);
          push_rtp_byte(fu_hdr, 1'b0, 1'b0, 1'b0);
          frag_left = (size > m) ? m : size;
        end
        frag_left--;
        push_rtp_byte(b, 1'b0, frag_left == 0, 1'b0);
      end
    end
    if (rtp_bytes_exp.size() > n0) begin
      tail = rtp_bytes_exp.pop_back();
      tail.run_last = 1'b1;
      rtp_bytes_exp.push_back(tail);
    end
    nal_pos = (pos + 1 >= nal_len) ? 0 : pos + 1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // One NAL unit; the length field is only meaningful on the first byte.
  function automatic void queue_nal_unit(input int unsigned len_field, input logic [7:0] hdr,
                                         input logic [7:0] hdr2, input bit std_prefix);
    int unsigned total;
    nal_byte_t   nb;
    total = (len_field < MIN_LEN) ? MIN_LEN : len_field;
    for (int unsigned i = 0; i < total; i++) begin
      nb.len = (i == 0) ? 24'(len_field) : 24'($urandom);
      if (i < PREFIX_LEN) nb.data = std_prefix ? ((i == PREFIX_LEN - 1) ? 8'h01 : 8'h00)
                                               : 8'($urandom);
      else if (i == PREFIX_LEN) nb.data = hdr;
      else if (i == PREFIX_LEN + 1) nb.data = hdr2;
      else nb.data = 8'($urandom);
      nal_bytes_pending.push_back(nb);
    end
    bytes_queued += total;
  endfunction

  function automatic int unsigned queue_random_unit();
    int unsigned m;
    int unsigned hi;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  hdr;
    logic [5:0]  htype;
    m = mtu_eff();
    hi = (3 * m > 24) ? 24 : 3 * m;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      hdr = (8'($urandom) & FUA_IND_MASK) | ($urandom_range(0, 1) ? AVC_IDR : AVC_NON_IDR);
    end else if (kind < 7) begin
      htype = $urandom_range(0, 1) ? HEVC_IDR : HEVC_TRAIL;
      hdr = (8'($urandom) & FU265_MASK) | {1'b0, htype, 1'b0};
    end else begin
      hdr = 8'($urandom);
    end
    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 4);
    else len = PREFIX_LEN + $urandom_range(1, hi);
    queue_nal_unit(len, hdr, 8'($urandom), $urandom_range(0, 4) != 0);
    return (len < MIN_LEN) ? MIN_LEN : len;
  endfunction

  // Wait until every queued byte is taken and every RTP byte has come out; start code
  // bytes leave nothing to wait for, so a quiet stretch follows.
  task automatic drain_and_settle();
    while (bytes_taken != bytes_queued || rtp_bytes_exp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mtu(input logic [11:0] value);
    @(negedge clk);
    mtu_we    <= 1'b1;
    mtu_wdata <= value;
    @(posedge clk);
    mtu_setting = value;
    mtu_writes++;
    @(negedge clk);
    mtu_we <= 1'b0;
  endtask

  // sender: one NAL byte request at a time
  always @(negedge clk) begin
    nal_byte_t nb;
    if (rst_n && (!push || nal_taken)) begin
      if (src_wait != 0) begin
        push     <= 1'b0;
        src_wait <= src_wait - 1;
      end else if (nal_bytes_pending.size() != 0) begin
        nb = nal_bytes_pending.pop_front();
        push       <= 1'b1;
        nal_byte   <= nb.data;
        nal_len_in <= nb.len;
        src_wait   <= src_idle_on ? $urandom_range(0, 5) : 0;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: long hold first, then per-byte stalls
  always @(negedge clk) begin
    if (sink_hold_cycles != 0) begin
      pop <= 1'b0;
      sink_hold_cycles--;
    end else if (sink_wait != 0) begin
      pop <= 1'b0;
      sink_wait--;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rtp_byte_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end else if (rst_n) begin
      if (pop && !empty) begin
        if (rtp_bytes_exp.size() == 0) begin
          $error("RTP byte 0x%0h with nothing expected", out_byte);
          mismatches++;
        end else begin
          want = rtp_bytes_exp.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("packet_first", want.first, out_first);
          check_field("packet_last", want.last, out_last);
          check_field("run_last", want.run_last, out_run_last);
          check_field("oversize_unsupported", want.unsup, out_unsup);
        end
        if (out_first) packets_seen++;
        rtp_bytes_checked++;
        sink_wait = sink_idle_on ? $urandom_range(0, 5) : 0;
      end
      nal_taken = push && !full;
      if (nal_taken) begin
        packetize_nal_byte(nal_byte, nal_len_in);
        bytes_taken++;
      end
    end
  end

  initial begin
    int unsigned sub;
    int unsigned phase_bytes;
    int unsigned random_bytes;
    sub = 0;
    random_bytes = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset MTU: short units, length field below five, unit that ends on its header
    @(posedge clk);
    queue_nal_unit(0, 8'hFF, 8'h00, 1'b1);
    queue_nal_unit(5, 8'h00, 8'h00, 1'b1);
    queue_nal_unit(12, 8'h41, 8'h01, 1'b1);
    drain_and_settle();

    // MTU floor: FU-A, both H.265 FU types, unsupported oversize, exact fit
    write_mtu(MTU_FLOOR);
    @(posedge clk);
    queue_nal_unit(22, 8'h65, 8'h00, 1'b1);
    queue_nal_unit(23, 8'h26, 8'h01, 1'b1);
    queue_nal_unit(23, 8'h83, 8'h01, 1'b1);
    queue_nal_unit(22, 8'h67, 8'h00, 1'b1);
    queue_nal_unit(20, 8'h45, 8'h00, 1'b1);
    // MTU change mid-unit: stop after the first fragment, then raise past the limit
    queue_nal_unit(45, 8'hE1, 8'h00, 1'b1);
    repeat (24) parked_bytes.push_front(nal_bytes_pending.pop_back());
    bytes_queued -= 24;
    drain_and_settle();
    write_mtu(12'hFFF);
    @(posedge clk);
    while (parked_bytes.size() != 0) nal_bytes_pending.push_back(parked_bytes.pop_front());
    bytes_queued += 24;
    drain_and_settle();
    write_mtu(12'h000);

    while (random_bytes < RANDOM_BYTES) begin
      case (sub % 5)
        0: if (sub != 0) write_mtu(12'($urandom_range(16, 28)));
        1: write_mtu(MTU_LIMIT);
        2: write_mtu(12'($urandom_range(17, 40)));
        3: write_mtu(12'($urandom_range(0, 4095)));
        default: write_mtu(MTU_FLOOR);
      endcase
      @(posedge clk);
      src_idle_on  = (sub % 3 != 1);
      sink_idle_on = (sub % 4 != 2);
      if (sub == 0) begin
        // receiver stalls while the sender keeps offering, so the input backs up
        src_idle_on = 1'b0;
        sink_hold_cycles = LONG_HOLD;
      end
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) phase_bytes += queue_random_unit();
      random_bytes += phase_bytes;
      drain_and_settle();
      sub++;
    end

    $display("Sent %0d NAL bytes; checked %0d RTP bytes in %0d packets", bytes_taken,
             rtp_bytes_checked, packets_seen);
    $display("MTU written %0d times across %0d random phases", mtu_writes, sub);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
